// ----- hw/rtl/ipv6fq_pkg.sv -----
// Shared types and constants for the IPv6 fragment queue.
`timescale 1ns / 1ps
`default_nettype none

package ipv6fq_pkg;

  // Result status codes
  typedef enum logic [3:0] {
    ST_OK             = 4'd0,
    ST_ALREADY        = 4'd1,
    ST_TOO_LARGE      = 4'd2,
    ST_FINAL_CONFLICT = 4'd3,
    ST_NOT_ROUNDED    = 4'd4,
    ST_BEYOND_FINAL   = 4'd5,
    ST_EMPTY          = 4'd6,
    ST_OVERLAP        = 4'd7,
    ST_FULL           = 4'd8
  } status_t;

  localparam logic OP_CLEAR = 1'b1;

  // Fragment offset lives in bits 15..3; the low three bits are flags.
  localparam logic [15:0] OFFSET_MASK = ~16'h0007;

  // Depth of the word queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified fragment word, as handed from front to back
  typedef struct packed {
    logic        clear;
    logic        more_frags;
    logic        too_large;
    logic        not_rounded;
    logic        empty;
    logic [15:0] start;
    logic [15:0] end_off;
    logic [15:0] length;
    logic [15:0] payload_length;
    logic [11:0] nh_offset;
  } frag_item_t;

  // One fragment table entry
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
  } frag_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ipv6fq_front.sv -----
// Front end: input handshake and stateless classification of each word.
`timescale 1ns / 1ps
`default_nettype none

module ipv6fq_front import ipv6fq_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_frag_word,
  input  logic [15:0] in_payload_length,
  input  logic [11:0] in_ext_header_bytes,
  input  logic [11:0] in_next_header_offset,
  input  logic        q_full,
  output logic        q_push,
  output frag_item_t  q_item
);

  logic [15:0] start;
  logic [18:0] end_s;   // two's complement, wide enough for -4095..131063

  always_comb begin
    start = in_frag_word & OFFSET_MASK;
    end_s = {3'b000, start} + {3'b000, in_payload_length}
            - {7'b0000000, in_ext_header_bytes};

    q_item.clear          = (in_opcode == OP_CLEAR);
    q_item.more_frags     = in_frag_word[0];
    q_item.too_large      = end_s[18] | (end_s[17:16] != 2'b00);
    q_item.not_rounded    = (end_s[2:0] != 3'b000);
    // only meaningful when the end is in range
    q_item.empty          = (end_s[15:0] <= start);
    q_item.start          = start;
    q_item.end_off        = end_s[15:0];
    q_item.length         = end_s[15:0] - start;
    q_item.payload_length = in_payload_length;
    q_item.nh_offset      = in_next_header_offset;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

endmodule

`default_nettype wire

// ----- hw/rtl/ipv6fq_queue.sv -----
// Short FIFO of classified words between front and back.
`timescale 1ns / 1ps
`default_nettype none

module ipv6fq_queue import ipv6fq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frag_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       nonempty,
  output frag_item_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);

  frag_item_t    slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [FW-1:0] fill_r;
  logic          do_push;
  logic          do_pop;

  assign full     = (fill_r == FILL_MAX);
  assign nonempty = (fill_r != '0);
  assign head     = slot_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ipv6fq_back.sv -----
// Back end: queue state, fragment table scan, insertion and result register.
`timescale 1ns / 1ps
`default_nettype none

module ipv6fq_back import ipv6fq_pkg::*; #(
  parameter int MAX_FRAGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nonempty,
  input  frag_item_t  q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [15:0] out_datagram_length,
  output logic [15:0] out_bytes_received,
  output logic [15:0] out_largest_payload,
  output logic        out_first_seen,
  output logic        out_final_seen,
  output logic        out_queue_dead,
  output logic [11:0] out_stored_nh_offset
);

  localparam int IW = $clog2(MAX_FRAGMENTS);
  localparam int CW = $clog2(MAX_FRAGMENTS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_FRAGMENTS);

  typedef enum logic [2:0] {S_IDLE, S_CLASS, S_SCAN, S_DECIDE, S_EMIT} state_t;

  frag_entry_t frag_mem [MAX_FRAGMENTS];
  frag_entry_t rd_r;

  state_t      state_r;
  frag_item_t  cur_r;
  status_t     status_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] ridx_r;
  logic        chk_r;
  logic        hit_r;
  logic [15:0] known_r;
  logic [15:0] total_r;
  logic [15:0] maxp_r;
  logic        dead_r;
  logic        first_r;
  logic        last_r;
  logic [11:0] nh_r;

  logic        out_valid_r;
  status_t     out_status_r;
  logic [15:0] out_len_r;
  logic [15:0] out_total_r;
  logic [15:0] out_maxp_r;
  logic        out_first_r;
  logic        out_last_r;
  logic        out_dead_r;
  logic [11:0] out_nh_r;

  logic issue;
  logic overlap;
  logic mem_we;
  logic out_free;

  // entry overlaps the new fragment if it starts before our end and ends after our start
  assign overlap  = (({1'b0, rd_r.start} + {1'b0, rd_r.length}) > {1'b0, cur_r.start})
                    && (rd_r.start < cur_r.end_off);
  assign issue    = (ridx_r < count_r);
  assign mem_we   = (state_r == S_DECIDE) && !hit_r && (count_r != COUNT_MAX);
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && q_nonempty;

  // table: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frag_mem[count_r[IW-1:0]] <= '{start: cur_r.start, length: cur_r.length};
    end
    rd_r <= frag_mem[ridx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ridx_r      <= '0;
      chk_r       <= 1'b0;
      hit_r       <= 1'b0;
      known_r     <= '0;
      total_r     <= '0;
      maxp_r      <= '0;
      dead_r      <= 1'b0;
      first_r     <= 1'b0;
      last_r      <= 1'b0;
      nh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_EMIT the result register is reloaded instead
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_nonempty) begin
            cur_r   <= q_head;
            state_r <= S_CLASS;
          end
        end
        S_CLASS: begin
          ridx_r <= '0;
          chk_r  <= 1'b0;
          hit_r  <= 1'b0;
          priority if (cur_r.clear) begin
            count_r  <= '0;
            known_r  <= '0;
            total_r  <= '0;
            maxp_r   <= '0;
            dead_r   <= 1'b0;
            first_r  <= 1'b0;
            last_r   <= 1'b0;
            nh_r     <= '0;
            status_r <= ST_OK;
            state_r  <= S_EMIT;
          end else if (dead_r) begin
            status_r <= ST_ALREADY;
            state_r  <= S_EMIT;
          end else if (cur_r.too_large) begin
            status_r <= ST_TOO_LARGE;
            state_r  <= S_EMIT;
          end else if (!cur_r.more_frags) begin
            if ((cur_r.end_off < known_r) || (last_r && (cur_r.end_off != known_r))) begin
              status_r <= ST_FINAL_CONFLICT;
              state_r  <= S_EMIT;
            end else begin
              last_r   <= 1'b1;
              known_r  <= cur_r.end_off;
              status_r <= ST_EMPTY;
              state_r  <= cur_r.empty ? S_EMIT : S_SCAN;
            end
          end else if (cur_r.not_rounded) begin
            status_r <= ST_NOT_ROUNDED;
            state_r  <= S_EMIT;
          end else if ((cur_r.end_off > known_r) && last_r) begin
            status_r <= ST_BEYOND_FINAL;
            state_r  <= S_EMIT;
          end else begin
            if (cur_r.end_off > known_r) begin
              known_r <= cur_r.end_off;
            end
            status_r <= ST_EMPTY;
            state_r  <= cur_r.empty ? S_EMIT : S_SCAN;
          end
        end
        S_SCAN: begin
          // read issued one cycle, compared the next
          if (issue) begin
            ridx_r <= ridx_r + 1'b1;
          end
          chk_r <= issue;
          if (chk_r && overlap) begin
            hit_r <= 1'b1;
          end
          if (!issue && !chk_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (hit_r) begin
            dead_r   <= 1'b1;
            status_r <= ST_OVERLAP;
          end else if (count_r == COUNT_MAX) begin
            status_r <= ST_FULL;
          end else begin
            count_r <= count_r + 1'b1;
            total_r <= total_r + cur_r.length;
            if (cur_r.payload_length > maxp_r) begin
              maxp_r <= cur_r.payload_length;
            end
            if (cur_r.start == '0) begin
              nh_r    <= cur_r.nh_offset;
              first_r <= 1'b1;
            end
            status_r <= ST_OK;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_len_r    <= known_r;
            out_total_r  <= total_r;
            out_maxp_r   <= maxp_r;
            out_first_r  <= first_r;
            out_last_r   <= last_r;
            out_dead_r   <= dead_r;
            out_nh_r     <= nh_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_datagram_length  = out_len_r;
  assign out_bytes_received   = out_total_r;
  assign out_largest_payload  = out_maxp_r;
  assign out_first_seen       = out_first_r;
  assign out_final_seen       = out_last_r;
  assign out_queue_dead       = out_dead_r;
  assign out_stored_nh_offset = out_nh_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ipv6_fragment_queue_insert.sv -----
// Top level: IPv6 fragment queue bookkeeping with overlap check.
// Flow: a word settled on its lengths or a clear goes from classification straight to the
//   result register; any other word first scans all n entries held in the table.
// Throughput: the back handles one word at a time, and a table scan is set by the
//   single read port of the table, one entry a cycle; up to two words wait in the queue.
// Reset: synchronous, active low; clears counters, flags and fill counts. The table is not
//   cleared; entries at or above the fill count are never compared.
`timescale 1ns / 1ps
`default_nettype none

module ipv6_fragment_queue_insert import ipv6fq_pkg::*; #(
  parameter int MAX_FRAGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_frag_word,
  input  logic [15:0] in_payload_length,
  input  logic [11:0] in_ext_header_bytes,
  input  logic [11:0] in_next_header_offset,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [15:0] out_datagram_length,
  output logic [15:0] out_bytes_received,
  output logic [15:0] out_largest_payload,
  output logic        out_first_seen,
  output logic        out_final_seen,
  output logic        out_queue_dead,
  output logic [11:0] out_stored_nh_offset
);

  // front -> queue
  logic       q_push;
  logic       q_full;
  frag_item_t q_item;
  // queue -> back
  logic       q_pop;
  logic       q_nonempty;
  frag_item_t q_head;

  // Front: works out start, end and length of the fragment, and the
  // state-free checks (range, rounding, empty), so the back only has to
  // compare against its own registers.
  ipv6fq_front u_front (
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_opcode             (in_opcode),
    .in_frag_word          (in_frag_word),
    .in_payload_length     (in_payload_length),
    .in_ext_header_bytes   (in_ext_header_bytes),
    .in_next_header_offset (in_next_header_offset),
    .q_full                (q_full),
    .q_push                (q_push),
    .q_item                (q_item)
  );

  // Decoupling queue: the front keeps taking words while the back scans, until the queue is full.
  ipv6fq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  // Back: final-length rules, then a scan of the table for overlap. The
  // table holds disjoint intervals, so checking every held entry gives the
  // same verdict as checking the sorted neighbours; entries are appended.
  ipv6fq_back #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_nonempty           (q_nonempty),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_datagram_length  (out_datagram_length),
    .out_bytes_received   (out_bytes_received),
    .out_largest_payload  (out_largest_payload),
    .out_first_seen       (out_first_seen),
    .out_final_seen       (out_final_seen),
    .out_queue_dead       (out_queue_dead),
    .out_stored_nh_offset (out_stored_nh_offset)
  );

  // back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nonempty)
    else $error("pop from empty word queue");

  // an overlap always kills the queue
  a_overlap_dead: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OVERLAP)) |-> out_queue_dead)
    else $error("overlap reported without dead queue");

  // refusal as already complete only on a dead queue
  a_already_dead: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_ALREADY)) |-> out_queue_dead)
    else $error("already-complete status on a live queue");

  // a stalled result stays valid until it is taken
  a_out_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

`default_nettype wire
